### design/lbs_pkg.sv
// Shared types and constants for the vertex skinning block.
// No dependencies; imported by the sequencer and the top level.
package lbs_pkg;

  localparam int BONE_W = 6;
  localparam int WORD_W = 4;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 32;
  localparam int WGT_W  = 17;
  localparam int SUM_W  = 48;
  localparam int PROD_W = 64;
  localparam int MUL_W  = 33;

  localparam logic [WORD_W-1:0] WORDS_PER_BONE = 4'd12;
  localparam logic [WORD_W-1:0] LAST_WORD      = 4'd11;
  localparam logic [1:0]        COL_TRANS      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_WMUL,
    ST_WACC,
    ST_EMIT
  } lbs_state_e;

  typedef struct packed {
    logic              in_ready;
    logic              rd_en;
    logic              mul_pos;
    logic              mul_wt;
    logic              add_prod;
    logic              add_trans;
    logic              clamp_c;
    logic              acc_sum;
    logic              clear_c;
    logic              emit;
    logic [WORD_W-1:0] wd;
  } lbs_ctl_t;

endpackage

### design/lbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/lbs_seq.sv
// Blend sequencer: walks the twelve matrix words of a bone and steps the datapath.
// Depends on lbs_pkg.
module lbs_seq
  import lbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     blend_i,
  input  logic     bone_ok_i,
  input  logic     last_i,
  input  logic     out_free_i,
  output lbs_ctl_t ctl_o
);

  lbs_state_e        state_q, state_d;
  logic [WORD_W-1:0] wd_q, wd_d;
  logic              last_q;
  logic              in_fire;
  logic              row_done;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign row_done = (wd_q == LAST_WORD);

  always_comb begin
    state_d = state_q;
    wd_d    = wd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && blend_i) begin
          wd_d = '0;
          if (bone_ok_i) begin
            state_d = ST_READ;
          end else if (last_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL: begin
        state_d = (wd_q[1:0] == COL_TRANS) ? ST_CLAMP : ST_ACC;
      end
      ST_ACC: begin
        wd_d    = wd_q + 1'b1;
        state_d = ST_READ;
      end
      ST_CLAMP: state_d = ST_WMUL;
      ST_WMUL:  state_d = ST_WACC;
      ST_WACC: begin
        if (row_done) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          wd_d    = wd_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.wd        = wd_q;
    ctl_o.in_ready  = (state_q == ST_IDLE);
    ctl_o.rd_en     = (state_q == ST_READ);
    ctl_o.mul_pos   = (state_q == ST_MUL) && (wd_q[1:0] != COL_TRANS);
    ctl_o.add_trans = (state_q == ST_MUL) && (wd_q[1:0] == COL_TRANS);
    ctl_o.add_prod  = (state_q == ST_ACC);
    ctl_o.clamp_c   = (state_q == ST_CLAMP);
    ctl_o.mul_wt    = (state_q == ST_WMUL);
    ctl_o.acc_sum   = (state_q == ST_WACC);
    ctl_o.clear_c   = (in_fire && blend_i) || ((state_q == ST_WACC) && !row_done);
    ctl_o.emit      = (state_q == ST_EMIT) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wd_q    <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wd_q    <= wd_d;
      if (in_fire && blend_i) begin
        last_q <= last_i;
      end
    end
  end

endmodule

### design/linear_blend_skinning_vertex.sv
// Top level of the linear blend skinning block: bone matrix store, multiply datapath, sums.
// Depends on lbs_pkg, lbs_ram and lbs_seq.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction per operation.
// A load (operation_i = 0) writes one Q16.16 matrix word into the bone store in
// the cycle it is accepted; out-of-range bone or word indexes are dropped.
// A blend (operation_i = 1) applies one bone influence to the running sums.
// Its twelve matrix words are read one per step through the single read port
// of the store; each row takes three read/multiply/accumulate steps (READ,
// MUL, ACC), a translation step (READ, MUL) and a weight step (CLAMP, WMUL,
// WACC), so in_ready_o stays low from acceptance until the last row is summed
// (and, when the blend is marked last, until the result leaves ST_EMIT).
// A blend marked last_influence_i produces one result on the output channel
// (out_valid_o / out_ready_i) by way of ST_EMIT after its last row, or after
// acceptance when the bone is out of range. A load leaves in_ready_o high.
// The result sits in an output register; new items are accepted while it
// waits. A further result waits in the sequencer until the register is taken.
// Reset clears the sums, the sticky saturation flag and all control state, but not the output
// registers; the bone store is not cleared and must be loaded before use.
module linear_blend_skinning_vertex
  import lbs_pkg::*;
#(
  parameter int BONES         = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [BONE_W-1:0]        bone_index_i,
  input  logic [WORD_W-1:0]        word_index_i,
  input  logic signed [POS_W-1:0]  matrix_word_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic [WGT_W-1:0]         weight_i,
  input  logic                     last_influence_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [POS_W-1:0]  skinned_x_o,
  output logic signed [POS_W-1:0]  skinned_y_o,
  output logic signed [POS_W-1:0]  skinned_z_o,
  output logic                     saturated_o
);

  localparam int DEPTH = BONES * int'(WORDS_PER_BONE);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = PROD_W - FRACTION_BITS + 2;

  lbs_ctl_t ctl;

  logic              bone_ok;
  logic              word_ok;
  logic              ram_we;
  logic [IDX_W-1:0]  bone_base;
  logic [IDX_W-1:0]  widx;
  logic [AW-1:0]     base_q;
  logic [AW-1:0]     raddr;
  logic [POS_W-1:0]  rdata;
  logic              out_free;

  logic signed [POS_W-1:0]  pos_q [3];
  logic [WGT_W-1:0]         w_q;
  logic signed [POS_W-1:0]  pos_sel;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [CW-1:0]     c_q;
  logic [CW-32:0]           c_hi;
  logic                     c_fits;
  logic signed [POS_W-1:0]  cc_d, cc_q;

  logic signed [SUM_W-1:0]  sum_q [3];
  logic signed [SUM_W-1:0]  sum_sel;
  logic signed [SUM_W:0]    sum_add;
  logic signed [SUM_W-1:0]  sum_new;
  logic                     sum_clip;
  logic                     sticky_q;

  logic signed [POS_W-1:0]  out_val [3];
  logic [2:0]               out_clip;
  logic                     out_valid_q;
  logic signed [POS_W-1:0]  out_q [3];
  logic                     sat_q;

  assign bone_ok   = int'(bone_index_i) < BONES;
  assign word_ok   = word_index_i < WORDS_PER_BONE;
  assign bone_base = (IDX_W'(bone_index_i) << 3) + (IDX_W'(bone_index_i) << 2);
  assign widx      = bone_base + IDX_W'(word_index_i);
  assign ram_we    = in_valid_i && ctl.in_ready && !operation_i && bone_ok && word_ok;
  assign raddr     = base_q + AW'(ctl.wd);
  assign out_free  = !out_valid_q || out_ready_i;

  lbs_ram #(
    .WIDTH (POS_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(widx)),
    .wdata_i (matrix_word_i),
    .re_i    (ctl.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lbs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .blend_i    (operation_i),
    .bone_ok_i  (bone_ok),
    .last_i     (last_influence_i),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  always_comb begin
    unique case (ctl.wd[1:0])
      2'd0:    pos_sel = pos_q[0];
      2'd1:    pos_sel = pos_q[1];
      default: pos_sel = pos_q[2];
    endcase
  end

  always_comb begin
    if (ctl.mul_wt) begin
      mul_a = {cc_q[POS_W-1], cc_q};
      mul_b = {{(MUL_W-WGT_W){1'b0}}, w_q};
    end else begin
      mul_a = {rdata[POS_W-1], rdata};
      mul_b = {pos_sel[POS_W-1], pos_sel};
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_sh = prod_q >>> FRACTION_BITS;

  assign c_hi   = c_q[CW-1:31];
  assign c_fits = (c_hi == '0) || (c_hi == '1);
  always_comb begin
    if (c_fits) begin
      cc_d = c_q[POS_W-1:0];
    end else if (c_q[CW-1]) begin
      cc_d = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      cc_d = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_comb begin
    unique case (ctl.wd[3:2])
      2'd0:    sum_sel = sum_q[0];
      2'd1:    sum_sel = sum_q[1];
      default: sum_sel = sum_q[2];
    endcase
    sum_add  = {sum_sel[SUM_W-1], sum_sel} + (SUM_W+1)'(prod_sh);
    sum_clip = sum_add[SUM_W] != sum_add[SUM_W-1];
    if (!sum_clip) begin
      sum_new = sum_add[SUM_W-1:0];
    end else if (sum_add[SUM_W]) begin
      sum_new = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_new = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_clip[r] = !((sum_q[r][SUM_W-1:31] == '0) || (sum_q[r][SUM_W-1:31] == '1));
      if (!out_clip[r]) begin
        out_val[r] = sum_q[r][POS_W-1:0];
      end else if (sum_q[r][SUM_W-1]) begin
        out_val[r] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        out_val[r] = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  // payload: hold operands and partial results
  always_ff @(posedge clk_i) begin
    if (in_valid_i && ctl.in_ready && operation_i) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      w_q      <= weight_i;
      base_q   <= AW'(bone_base);
    end
    if (ctl.mul_pos || ctl.mul_wt) begin
      prod_q <= mul_p[PROD_W-1:0];
    end
    if (ctl.clear_c) begin
      c_q <= '0;
    end else if (ctl.add_prod) begin
      c_q <= c_q + CW'(prod_sh);
    end else if (ctl.add_trans) begin
      c_q <= c_q + CW'($signed(rdata));
    end
    if (ctl.clamp_c) begin
      cc_q <= cc_d;
    end
    if (ctl.emit) begin
      out_q[0] <= out_val[0];
      out_q[1] <= out_val[1];
      out_q[2] <= out_val[2];
      sat_q    <= sticky_q || (|out_clip);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl.emit) begin
        sum_q[0] <= '0;
        sum_q[1] <= '0;
        sum_q[2] <= '0;
        sticky_q <= 1'b0;
      end else begin
        for (int r = 0; r < 3; r++) begin
          if (ctl.acc_sum && (ctl.wd[3:2] == 2'(r))) begin
            sum_q[r] <= sum_new;
          end
        end
        if ((ctl.clamp_c && !c_fits) || (ctl.acc_sum && sum_clip)) begin
          sticky_q <= 1'b1;
        end
      end
      if (ctl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = ctl.in_ready;
  assign out_valid_o = out_valid_q;
  assign skinned_x_o = out_q[0];
  assign skinned_y_o = out_q[1];
  assign skinned_z_o = out_q[2];
  assign saturated_o = sat_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ctl.rd_en))
    else $error("store write during blend read");

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rd_en |-> (ctl.wd <= LAST_WORD))
    else $error("word counter beyond last matrix word");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites pending output");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |=> (!sticky_q && out_valid_q))
    else $error("sums not cleared after result");

endmodule
